[hdl/qrf_pkg.sv]
`timescale 1ns / 1ps

package qrf_pkg;

  // transaction field widths on the stream ports
  localparam int COORD_W    = 11;
  localparam int NUM_CORNER = 4;
  localparam int IN_DATA_W  = 88;
  localparam int RES_W      = 24;
  localparam int OUT_DATA_W = 56;

  // configuration registers
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int MIN_AREA_W  = 23;
  localparam int COS_LIMIT_W = 9;
  localparam int MIN_SIDE_W  = 24;

  localparam logic [MIN_AREA_W-1:0]  MIN_AREA_RST  = 23'd1000;
  localparam logic [COS_LIMIT_W-1:0] COS_LIMIT_RST = 9'd77;
  localparam logic [MIN_SIDE_W-1:0]  MIN_SIDE_RST  = 24'd10000;

  // cosine limit is in 1/256 units; squared on both sides of the compare
  localparam int COS_FRAC_BITS = 8;
  localparam int CSQ_W         = 2 * COS_LIMIT_W;

  localparam logic [RES_W-1:0] SAT24 = 24'hFFFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_AREA  = 2'd0,
    CFG_COS_LIMIT = 2'd1,
    CFG_MIN_SIDE  = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    FAIL_NONE   = 3'd0,
    FAIL_CONVEX = 3'd1,
    FAIL_AREA   = 3'd2,
    FAIL_ANGLE  = 3'd3,
    FAIL_RATIO  = 3'd4,
    FAIL_SIDE   = 3'd5
  } fail_code_t;

  // load enables of the pipeline stages that the corner units share
  typedef struct packed {
    logic s3;
    logic s4;
  } stage_adv_t;

endpackage

[hdl/qrf_corner.sv]
`timescale 1ns / 1ps

module qrf_corner #(
  parameter int COORD_BITS = 11
) (
  input  logic                      clk,
  input  qrf_pkg::stage_adv_t       adv,
  input  logic [2*COORD_BITS:0]     la,
  input  logic [2*COORD_BITS:0]     lb,
  input  logic signed [2*COORD_BITS+1:0] dot,
  input  logic [qrf_pkg::CSQ_W-1:0] c_sq,
  input  logic                      c_nz,
  output logic                      ok
);

  localparam int LW  = 2 * COORD_BITS + 1;
  localparam int PW  = 2 * COORD_BITS + 2;
  localparam int MW  = 2 * LW;
  localparam int SHW = 2 * qrf_pkg::COS_FRAC_BITS;
  localparam int HW  = 2 * LW + SHW;
  localparam int XW  = 2 * LW + qrf_pkg::CSQ_W;

  logic [LW-1:0]   ad3;
  logic [2*LW-1:0] pll3;
  logic            zero3;
  logic [HW-1:0]   lhs4;
  logic [XW-1:0]   rhs4;
  logic            zero4;
  logic            cnz4;

  logic signed [PW-1:0] dot_neg;
  logic [2*LW-1:0]      ad_sq;

  assign dot_neg = -dot;

  // stage 3: magnitude of the dot product, product of the squared legs
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      ad3   <= dot[PW-1] ? dot_neg[LW-1:0] : dot[LW-1:0];
      pll3  <= MW'(la) * MW'(lb);
      zero3 <= (dot == '0);
    end
  end

  assign ad_sq = MW'(ad3) * MW'(ad3);

  // stage 4: 65536*dot^2 against c^2*|a|^2*|b|^2
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      lhs4  <= {ad_sq, {SHW{1'b0}}};
      rhs4  <= XW'(pll3) * XW'(c_sq);
      zero4 <= zero3;
      cnz4  <= c_nz;
    end
  end

  // a right angle passes whenever the limit is nonzero
  assign ok = zero4 ? cnz4 : (XW'(lhs4) < rhs4);

endmodule

[hdl/quad_rectangle_filter_core.sv]
`timescale 1ns / 1ps

// Quadrilateral squareness filter.
// Input stream s_*: one transaction carries the four corners (x0,y0)..(x3,y3)
// of a candidate polygon. Output stream m_*: one result per input, in order,
// with the accept flag, the code of the first failing test, twice the area
// and the squared side 0-1 (both saturated at 24 bits).
// Configuration: write cfg_data to register cfg_index while cfg_we is high
// (0 min_area, 1 cos_limit, 2 min_side_sq); write only while no result is
// pending.
// Throughput: one transaction per cycle while m_tready does not hold the
// output, set by the five register stages (edge vectors, products, sums and
// leg products, squared dot and limit products, final compare); no stage
// holds more than one level of multipliers.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults 1000, 77 and 10000.
// When m_tready is low the result holds on m_tdata; stages behind it keep
// filling, and s_tready falls only when all five stages hold a transaction.
module quad_rectangle_filter_core #(
  parameter int COORD_BITS = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x0, y0, x1, y1, x2, y2, x3, y3 (11 bits each)
  input  logic [qrf_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // accept, fail_code[2:0], area_twice[23:0], side_sq[23:0], zero pad
  output logic [qrf_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [qrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qrf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int N  = COORD_BITS;
  localparam int DW = N + 1;
  localparam int MW = 2 * N;
  localparam int PW = 2 * N + 2;
  localparam int LW = 2 * N + 1;
  localparam int TW = 2 * N + 3;
  localparam int AW = 2 * N + 2;
  localparam int QW = qrf_pkg::CSQ_W;
  localparam int XW = 2 * LW + qrf_pkg::CSQ_W;
  localparam int NC = qrf_pkg::NUM_CORNER;
  localparam int CW = qrf_pkg::COORD_W;
  localparam int RW = qrf_pkg::RES_W;

  // configuration
  logic [qrf_pkg::MIN_AREA_W-1:0]  min_area;
  logic [qrf_pkg::COS_LIMIT_W-1:0] cos_limit;
  logic [qrf_pkg::MIN_SIDE_W-1:0]  min_side_sq;
  logic [qrf_pkg::CSQ_W-1:0]       c_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_area    <= qrf_pkg::MIN_AREA_RST;
      cos_limit   <= qrf_pkg::COS_LIMIT_RST;
      min_side_sq <= qrf_pkg::MIN_SIDE_RST;
    end else if (cfg_we) begin
      case (qrf_pkg::cfg_index_t'(cfg_index))
        qrf_pkg::CFG_MIN_AREA:  min_area    <= cfg_data[qrf_pkg::MIN_AREA_W-1:0];
        qrf_pkg::CFG_COS_LIMIT: cos_limit   <= cfg_data[qrf_pkg::COS_LIMIT_W-1:0];
        qrf_pkg::CFG_MIN_SIDE:  min_side_sq <= cfg_data[qrf_pkg::MIN_SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    c_sq <= QW'(cos_limit) * QW'(cos_limit);
  end

  // pipeline flow control
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  qrf_pkg::stage_adv_t adv;

  assign rdy5     = !v5 || m_tready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign m_tvalid = v5;
  assign adv.s3   = rdy3;
  assign adv.s4   = rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: corners and edge vectors e[i] = p[i+1] - p[i]
  logic [N-1:0] cx [NC];
  logic [N-1:0] cy [NC];
  logic [N-1:0] xq [NC];
  logic [N-1:0] yq [NC];
  logic signed [DW-1:0] ex1 [NC];
  logic signed [DW-1:0] ey1 [NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      cx[i] = N'(s_tdata[2*i*CW +: CW]);
      cy[i] = N'(s_tdata[(2*i+1)*CW +: CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < NC; i++) begin
        xq[i]  <= cx[i];
        yq[i]  <= cy[i];
        ex1[i] <= $signed({1'b0, cx[(i+1)%NC]}) - $signed({1'b0, cx[i]});
        ey1[i] <= $signed({1'b0, cy[(i+1)%NC]}) - $signed({1'b0, cy[i]});
      end
    end
  end

  // stage 2: cross products, shoelace terms, squared edges, corner dots
  logic [2*N-1:0]       prod_ab [NC];
  logic [2*N-1:0]       prod_ba [NC];
  logic signed [PW-1:0] sqx [NC];
  logic signed [PW-1:0] sqy [NC];
  logic signed [PW-1:0] cr2 [NC];
  logic signed [TW-1:0] term2 [NC];
  logic [LW-1:0]        len2 [NC];
  logic signed [PW-1:0] dot2 [NC-1];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      prod_ab[i] = MW'(xq[i]) * MW'(yq[(i+1)%NC]);
      prod_ba[i] = MW'(xq[(i+1)%NC]) * MW'(yq[i]);
      sqx[i]     = PW'(ex1[i]) * PW'(ex1[i]);
      sqy[i]     = PW'(ey1[i]) * PW'(ey1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < NC; i++) begin
        cr2[i]   <= PW'(ex1[i]) * PW'(ey1[(i+1)%NC]) - PW'(ey1[i]) * PW'(ex1[(i+1)%NC]);
        term2[i] <= $signed({3'b000, prod_ab[i]}) - $signed({3'b000, prod_ba[i]});
        len2[i]  <= {1'b0, sqx[i][2*N-1:0]} + {1'b0, sqy[i][2*N-1:0]};
      end
      // the corner between edges k and k+1 sits at point k+1
      for (int k = 0; k < NC - 1; k++) begin
        dot2[k] <= PW'(ex1[k]) * PW'(ex1[k+1]) + PW'(ey1[k]) * PW'(ey1[k+1]);
      end
    end
  end

  // corner cosine checks at points 1, 2 and 3, stages 3 and 4
  logic [NC-2:0] corner_ok;

  for (genvar k = 0; k < NC - 1; k++) begin : g_corner
    qrf_corner #(
      .COORD_BITS(COORD_BITS)
    ) u_corner (
      .clk  (clk),
      .adv  (adv),
      .la   (len2[k]),
      .lb   (len2[k+1]),
      .dot  (dot2[k]),
      .c_sq (c_sq),
      .c_nz (cos_limit != '0),
      .ok   (corner_ok[k])
    );
  end

  // stage 3: convexity, area, side ratio and side length
  logic signed [TW-1:0] sum_s;
  logic                 all_pos;
  logic                 all_neg;
  logic                 conv3;
  logic [AW-1:0]        area3;
  logic [LW-1:0]        s01_3;
  logic                 ratio3;
  logic                 side_fail3;

  always_comb begin
    sum_s   = term2[0] + term2[1] + term2[2] + term2[3];
    all_pos = 1'b1;
    all_neg = 1'b1;
    for (int i = 0; i < NC; i++) begin
      if (!(cr2[i] > 0)) all_pos = 1'b0;
      if (!(cr2[i] < 0)) all_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      conv3      <= all_pos || all_neg;
      area3      <= AW'(sum_s < 0 ? -sum_s : sum_s);
      s01_3      <= len2[0];
      ratio3     <= (len2[1] != '0) && ({len2[0], 1'b0} > {1'b0, len2[1]}) &&
                    ({1'b0, len2[0]} < {len2[1], 1'b0});
      side_fail3 <= (min_side_sq != '0) && !(XW'(len2[0]) > XW'(min_side_sq));
    end
  end

  // stage 4: area threshold, hold the rest beside the corner products
  logic          conv4;
  logic          area_ok4;
  logic [AW-1:0] area4;
  logic [LW-1:0] s01_4;
  logic          ratio4;
  logic          side_fail4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      conv4      <= conv3;
      area_ok4   <= XW'(area3) > XW'({min_area, 1'b0});
      area4      <= area3;
      s01_4      <= s01_3;
      ratio4     <= ratio3;
      side_fail4 <= side_fail3;
    end
  end

  // stage 5: first failing test, saturate the reported values
  qrf_pkg::fail_code_t code_next;
  qrf_pkg::fail_code_t out_code;
  logic                out_accept;
  logic [RW-1:0]       out_area;
  logic [RW-1:0]       out_side;

  always_comb begin
    if (!conv4) begin
      code_next = qrf_pkg::FAIL_CONVEX;
    end else if (!area_ok4) begin
      code_next = qrf_pkg::FAIL_AREA;
    end else if (!(&corner_ok)) begin
      code_next = qrf_pkg::FAIL_ANGLE;
    end else if (!ratio4) begin
      code_next = qrf_pkg::FAIL_RATIO;
    end else if (side_fail4) begin
      code_next = qrf_pkg::FAIL_SIDE;
    end else begin
      code_next = qrf_pkg::FAIL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_code   <= code_next;
      out_accept <= (code_next == qrf_pkg::FAIL_NONE);
      out_area   <= (XW'(area4) > XW'(qrf_pkg::SAT24)) ? qrf_pkg::SAT24 : RW'(area4);
      out_side   <= (XW'(s01_4) > XW'(qrf_pkg::SAT24)) ? qrf_pkg::SAT24 : RW'(s01_4);
    end
  end

  assign m_tdata = {{(qrf_pkg::OUT_DATA_W - 2*RW - 4){1'b0}},
                    out_side, out_area, out_code, out_accept};

`ifndef NO_ASSERTIONS
  // reset leaves no result on the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // input stalls only when every stage is occupied and the output is blocked
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && v5 && !m_tready))
    else $error("input stalled with room in the pipeline");

  // an accepted transaction lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted transaction lost at stage 1");

  // a blocked stage 4 keeps its transaction
  a_hold4: assert property (@(posedge clk) disable iff (rst)
    v4 && !rdy5 |=> v4 && $stable(area4) && $stable(s01_4))
    else $error("stage 4 changed while blocked");
`endif

endmodule

[tb/tb_quad_rectangle_filter_core.sv]
`timescale 1ns / 1ps

module tb_quad_rectangle_filter_core;

  localparam int COORD_BITS = 11;
  localparam longint COORD_MASK = (longint'(1) << COORD_BITS) - 1;
  localparam logic [qrf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int STALL_PCT = 29;
  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int NCORN = qrf_pkg::NUM_CORNER;
  localparam int CRDW = qrf_pkg::COORD_W;
  localparam int RESW = qrf_pkg::RES_W;

  typedef struct packed {
    logic                  accept;
    qrf_pkg::fail_code_t   code;
    logic [RESW-1:0]       area_twice;
    logic [RESW-1:0]       side_sq;
  } quad_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [qrf_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [qrf_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [qrf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [qrf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // thresholds as the block should hold them
  logic [qrf_pkg::MIN_AREA_W-1:0]  cur_min_area  = qrf_pkg::MIN_AREA_RST;
  logic [qrf_pkg::COS_LIMIT_W-1:0] cur_cos_limit = qrf_pkg::COS_LIMIT_RST;
  logic [qrf_pkg::MIN_SIDE_W-1:0]  cur_min_side  = qrf_pkg::MIN_SIDE_RST;

  logic [qrf_pkg::IN_DATA_W-1:0] pending_quads[$];
  quad_verdict_t expected_verdicts[$];

  bit calm = 1'b0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  quad_rectangle_filter_core #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // |cos| < c/256 at vertex v, compared squared with exact wide products
  function automatic bit corner_fits(input longint p_x, input longint p_y,
                                     input longint v_x, input longint v_y,
                                     input longint q_x, input longint q_y,
                                     input logic [qrf_pkg::COS_LIMIT_W-1:0] c);
    longint ax, ay, bx, by, dot;
    longint unsigned la, lb, ad;
    logic [127:0] lhs, rhs;
    ax = p_x - v_x;
    ay = p_y - v_y;
    bx = q_x - v_x;
    by = q_y - v_y;
    dot = ax * bx + ay * by;
    la = ax * ax + ay * ay;
    lb = bx * bx + by * by;
    ad = (dot < 0) ? -dot : dot;
    // right angle or zero-length leg: cosine counts as zero
    if (ad == 0) return c != 0;
    lhs = 128'(ad) * 128'(ad);
    lhs = lhs << (2 * qrf_pkg::COS_FRAC_BITS);
    rhs = 128'(la) * 128'(lb) * 128'(c) * 128'(c);
    return lhs < rhs;
  endfunction

  function automatic quad_verdict_t judge_quad(input logic [qrf_pkg::IN_DATA_W-1:0] d);
    longint px[4], py[4];
    longint ex, ey, fx, fy, cr, shoelace;
    longint unsigned area, area_floor, s01, s12;
    int pos, neg, a, b, c;
    quad_verdict_t v;
    pos = 0;
    neg = 0;
    shoelace = 0;
    for (int i = 0; i < NCORN; i++) begin
      px[i] = longint'(d[2*CRDW*i +: CRDW]) & COORD_MASK;
      py[i] = longint'(d[2*CRDW*i+CRDW +: CRDW]) & COORD_MASK;
    end
    for (int i = 0; i < NCORN; i++) begin
      a = i;
      b = (i + 1) % NCORN;
      c = (i + 2) % NCORN;
      ex = px[b] - px[a];
      ey = py[b] - py[a];
      fx = px[c] - px[b];
      fy = py[c] - py[b];
      cr = ex * fy - ey * fx;
      if (cr > 0) pos++;
      else if (cr < 0) neg++;
      shoelace += px[a] * py[b] - px[b] * py[a];
    end
    area = (shoelace < 0) ? -shoelace : shoelace;
    s01 = (px[0] - px[1]) * (px[0] - px[1]) + (py[0] - py[1]) * (py[0] - py[1]);
    s12 = (px[1] - px[2]) * (px[1] - px[2]) + (py[1] - py[2]) * (py[1] - py[2]);
    area_floor = cur_min_area;
    area_floor = area_floor * 2;

    if (!(pos == NCORN || neg == NCORN))
      v.code = qrf_pkg::FAIL_CONVEX;
    else if (!(area > area_floor))
      v.code = qrf_pkg::FAIL_AREA;
    else if (!(corner_fits(px[0], py[0], px[1], py[1], px[2], py[2], cur_cos_limit) &&
               corner_fits(px[1], py[1], px[2], py[2], px[3], py[3], cur_cos_limit) &&
               corner_fits(px[2], py[2], px[3], py[3], px[0], py[0], cur_cos_limit)))
      v.code = qrf_pkg::FAIL_ANGLE;
    else if (!(s12 > 0 && 2 * s01 > s12 && s01 < 2 * s12))
      v.code = qrf_pkg::FAIL_RATIO;
    else if (cur_min_side != 0 && !(s01 > cur_min_side))
      v.code = qrf_pkg::FAIL_SIDE;
    else
      v.code = qrf_pkg::FAIL_NONE;

    v.accept = (v.code == qrf_pkg::FAIL_NONE);
    v.area_twice = (area > qrf_pkg::SAT24) ? qrf_pkg::SAT24 : area[RESW-1:0];
    v.side_sq = (s01 > qrf_pkg::SAT24) ? qrf_pkg::SAT24 : s01[RESW-1:0];
    return v;
  endfunction

  function automatic logic [qrf_pkg::IN_DATA_W-1:0] pack_quad(input int c[8]);
    logic [qrf_pkg::IN_DATA_W-1:0] d;
    for (int k = 0; k < 2 * NCORN; k++)
      d[CRDW*k +: CRDW] = c[k][CRDW-1:0];
    return d;
  endfunction

  function automatic logic [qrf_pkg::IN_DATA_W-1:0] random_quad();
    int qx[4], qy[4], d[8];
    int pick, s, u, v, wx, wy, jit, minx, maxx, miny, maxy, offx, offy, rot, rev, idx;
    pick = $urandom_range(99);
    s = ($urandom_range(2) == 0) ? $urandom_range(3, 120) : $urandom_range(120, 700);
    u = $urandom_range(s);
    v = s - u;
    if ($urandom_range(1)) u = -u;
    if ($urandom_range(1)) v = -v;
    jit = s / 3 + 1;
    wx = -v + $urandom_range(2 * jit) - jit;
    wy = u + $urandom_range(2 * jit) - jit;
    // stretched or squashed second side for the ratio test
    if (pick >= 88) begin
      if ($urandom_range(1)) begin
        wx = wx * 2;
        wy = wy * 2;
      end else begin
        wx = wx / 3;
        wy = wy / 3;
      end
    end
    qx[0] = 0;       qy[0] = 0;
    qx[1] = u;       qy[1] = v;
    qx[2] = u + wx;  qy[2] = v + wy;
    qx[3] = wx;      qy[3] = wy;
    for (int k = 0; k < NCORN; k++) begin
      qx[k] += $urandom_range(6) - 3;
      qy[k] += $urandom_range(6) - 3;
    end
    minx = qx[0]; maxx = qx[0]; miny = qy[0]; maxy = qy[0];
    for (int k = 1; k < NCORN; k++) begin
      if (qx[k] < minx) minx = qx[k];
      if (qx[k] > maxx) maxx = qx[k];
      if (qy[k] < miny) miny = qy[k];
      if (qy[k] > maxy) maxy = qy[k];
    end
    if (pick < 25 || maxx - minx > 2047 || maxy - miny > 2047) begin
      for (int k = 0; k < 2 * NCORN; k++) d[k] = $urandom_range(2047);
      return pack_quad(d);
    end
    offx = $urandom_range(2047 - (maxx - minx)) - minx;
    offy = $urandom_range(2047 - (maxy - miny)) - miny;
    // push against the edges now and then so the top coordinates show up
    if ($urandom_range(9) == 0) offx = $urandom_range(1) ? -minx : 2047 - maxx;
    if ($urandom_range(9) == 0) offy = $urandom_range(1) ? -miny : 2047 - maxy;
    rot = $urandom_range(3);
    rev = $urandom_range(1);
    for (int k = 0; k < NCORN; k++) begin
      idx = rev ? (rot - k) & 3 : (rot + k) & 3;
      d[2*k] = qx[idx] + offx;
      d[2*k+1] = qy[idx] + offy;
    end
    return pack_quad(d);
  endfunction

  task automatic push_quad(input int c[8]);
    pending_quads = {pending_quads, pack_quad(c)};
  endtask

  task automatic run_quads(input int n);
    @(negedge clk);
    for (int i = 0; i < n; i++) pending_quads = {pending_quads, random_quad()};
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    while (pending_quads.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [qrf_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [qrf_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      qrf_pkg::CFG_MIN_AREA:  cur_min_area = value[qrf_pkg::MIN_AREA_W-1:0];
      qrf_pkg::CFG_COS_LIMIT: cur_cos_limit = value[qrf_pkg::COS_LIMIT_W-1:0];
      qrf_pkg::CFG_MIN_SIDE:  cur_min_side = value[qrf_pkg::MIN_SIDE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // input side: present queued quads, idle at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_quads.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_quads.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    quad_verdict_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result transaction: %h", m_tdata);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (m_tdata[0] !== want.accept) begin
            $error("accept: expected %0d, got %0d", want.accept, m_tdata[0]);
            mismatches++;
          end
          if (m_tdata[3:1] !== want.code) begin
            $error("fail_code: expected %0d, got %0d", want.code, m_tdata[3:1]);
            mismatches++;
          end
          if (m_tdata[27:4] !== want.area_twice) begin
            $error("area_twice: expected %0d, got %0d", want.area_twice, m_tdata[27:4]);
            mismatches++;
          end
          if (m_tdata[51:28] !== want.side_sq) begin
            $error("side_sq: expected %0d, got %0d", want.side_sq, m_tdata[51:28]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_verdicts = {expected_verdicts, judge_quad(s_tdata)};
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default thresholds: 1000, 77, 10000
    @(negedge clk);
    push_quad('{0, 0, 200, 0, 200, 200, 0, 200});          // square, pass
    push_quad('{0, 200, 200, 200, 200, 0, 0, 0});          // opposite winding
    push_quad('{0, 0, 0, 0, 0, 0, 0, 0});                  // all zero
    push_quad('{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047});
    push_quad('{0, 0, 2047, 0, 2047, 2047, 0, 2047});      // largest square
    push_quad('{2047, 2047, 0, 2047, 0, 0, 2047, 0});
    push_quad('{0, 0, 100, 0, 200, 0, 100, 100});          // collinear corners
    push_quad('{0, 0, 100, 100, 100, 0, 0, 100});          // bow tie
    push_quad('{0, 0, 200, 0, 50, 50, 0, 200});            // concave
    push_quad('{0, 0, 0, 0, 100, 0, 100, 100});            // zero-length edge
    push_quad('{0, 0, 100, 0, 100, 0, 0, 100});            // zero second side
    push_quad('{5, 5, 15, 5, 15, 15, 5, 15});              // too small
    push_quad('{0, 0, 40, 0, 40, 25, 0, 25});              // area exactly at floor
    push_quad('{0, 0, 300, 0, 500, 300, 200, 300});        // sharp parallelogram
    push_quad('{0, 0, 400, 0, 400, 100, 0, 100});          // long rectangle
    push_quad('{0, 0, 100, 0, 100, 140, 0, 140});          // side exactly at floor
    push_quad('{0, 0, 90, 0, 90, 90, 0, 90});              // side short
    push_quad('{0, 100, 100, 0, 200, 100, 100, 200});      // rotated square
    push_quad('{0, 0, 300, 0, 330, 300, 30, 300});         // slight skew, pass
    push_quad('{1024, 1024, 1535, 1024, 1535, 1535, 1024, 1535});
    run_quads(150);
    wait_for_drain();

    // looser profile; high bits beyond each register width must be dropped
    write_threshold(qrf_pkg::CFG_MIN_AREA, 24'h800320);
    write_threshold(qrf_pkg::CFG_COS_LIMIT, 24'hFFFE9A);
    write_threshold(qrf_pkg::CFG_MIN_SIDE, 24'd0);
    run_quads(200);
    hold_arm = 1'b1;
    wait_for_drain();

    // wide limits, no idling on either side
    write_threshold(qrf_pkg::CFG_MIN_AREA, 24'd0);
    write_threshold(qrf_pkg::CFG_COS_LIMIT, 24'd256);
    write_threshold(qrf_pkg::CFG_MIN_SIDE, 24'd1);
    calm = 1'b1;
    run_quads(150);
    wait_for_drain();
    calm = 1'b0;

    // zero cosine limit fails every convex quad at the angle test
    write_threshold(qrf_pkg::CFG_COS_LIMIT, 24'd0);
    write_threshold(qrf_pkg::CFG_MIN_SIDE, 24'hFFFFFF);
    run_quads(100);
    wait_for_drain();

    // largest area floor; the spare index must not touch anything
    write_threshold(qrf_pkg::CFG_MIN_AREA, 24'h7FFFFF);
    write_threshold(qrf_pkg::CFG_COS_LIMIT, 24'd511);
    write_threshold(qrf_pkg::CFG_MIN_SIDE, 24'd5000);
    write_threshold(CFG_UNUSED_IDX, 24'hA5A5A5);
    run_quads(100);
    wait_for_drain();

    write_threshold(qrf_pkg::CFG_MIN_AREA, 24'($urandom_range(20000)));
    write_threshold(qrf_pkg::CFG_COS_LIMIT, 24'($urandom_range(40, 200)));
    write_threshold(qrf_pkg::CFG_MIN_SIDE, 24'($urandom_range(200000)));
    run_quads(250);
    wait_for_drain();

    write_threshold(qrf_pkg::CFG_MIN_AREA, 24'd1000);
    write_threshold(qrf_pkg::CFG_COS_LIMIT, 24'd77);
    write_threshold(qrf_pkg::CFG_MIN_SIDE, 24'd10000);
    run_quads(100);
    wait_for_drain();

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
